>>> rtl/lprf_pkg.sv
// Package for the longest pixel run finder.
// Holds sizes, register indexes and the structs passed between modules; no dependencies.
`timescale 1ns / 1ps

package lprf_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W    = 11;
    localparam int LEN_W    = 11;
    localparam int POS_W    = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd2;

    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [ROW_W-1:0] rows_m1;
        logic [COL_W-1:0] cols_m1;
        logic             dir;
    } t_cfg;

    typedef struct packed {
        logic             set;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             dir;
        logic             last;
    } t_pix;

endpackage

>>> rtl/longest_pixel_run_finder.sv
// Longest pixel run finder: one pixel word per clock, set by the single read-modify-write of
// the column store (read port at accept, write port when that pixel completes, with forwarding),
// except that the last pixel stalls while the previous result is held; it then registers the result.
// Synchronous active-low reset clears counters, run state and configuration (1 x 1, horizontal);
// the column store is not cleared, its entries are written before they are read.
// Depends on lprf_pkg, lprf_cfg, lprf_ram and lprf_track.
`timescale 1ns / 1ps

module longest_pixel_run_finder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lprf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lprf_pkg::CNT_W-1:0]      i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pixel, zero fill
    input  logic [7:0]                      s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // run_length, start_row, start_col, end_row, end_col, zero fill
    output logic [lprf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // found
    output logic                            m_axis_tuser
);
    import lprf_pkg::*;

    t_cfg             cfg;
    t_pix             pix;
    logic             accept;
    logic             hold;
    logic             row_end;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] rd_addr;
    logic [LEN_W-1:0] rd_data;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [LEN_W-1:0] wr_data;

    lprf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign row_end = r_col >= cfg.cols_m1;

    always_comb begin
        pix.set  = s_axis_tdata[0];
        pix.row  = r_row;
        pix.col  = r_col;
        pix.dir  = cfg.dir;
        pix.last = row_end && (r_row >= cfg.rows_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (pix.last) begin
                r_row <= '0;
                r_col <= '0;
            end else if (row_end) begin
                r_row <= r_row + ROW_W'(1);
                r_col <= '0;
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    assign rd_addr = hold ? wr_addr : r_col;

    lprf_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_COLS)
    ) u_col_runs (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lprf_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_pix      (pix),
        .o_ready    (s_axis_tready),
        .o_hold     (hold),
        .i_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

>>> rtl/lprf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; read during write to the same address returns the old data.
`timescale 1ns / 1ps

module lprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/lprf_cfg.sv
// Configuration registers: image size (stored clamped, minus one) and run direction.
// Depends on lprf_pkg.
`timescale 1ns / 1ps

module lprf_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lprf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lprf_pkg::CNT_W-1:0]    i_cfg_data,
    output lprf_pkg::t_cfg                o_cfg
);
    import lprf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic [ROW_W-1:0] rows_m1;
    logic [COL_W-1:0] cols_m1;

    always_comb begin
        if (i_cfg_data == '0) begin
            rows_m1 = '0;
        end else if (32'(i_cfg_data) > 32'(MAX_ROWS)) begin
            rows_m1 = ROW_W'(MAX_ROWS - 1);
        end else begin
            rows_m1 = ROW_W'(i_cfg_data - CNT_W'(1));
        end
        if (i_cfg_data == '0) begin
            cols_m1 = '0;
        end else if (32'(i_cfg_data) > 32'(MAX_COLS)) begin
            cols_m1 = COL_W'(MAX_COLS - 1);
        end else begin
            cols_m1 = COL_W'(i_cfg_data - CNT_W'(1));
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROW_COUNT: n_cfg.rows_m1 = rows_m1;
                REG_COL_COUNT: n_cfg.cols_m1 = cols_m1;
                REG_DIRECTION: n_cfg.dir     = i_cfg_data[0];
                default:       n_cfg         = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

>>> rtl/lprf_track.sv
// Run tracking stage: read-modify-write of the column store, best-run update and result register.
// Depends on lprf_pkg; drives the write port of the column store RAM.
`timescale 1ns / 1ps

module lprf_track (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  lprf_pkg::t_pix                i_pix,
    output logic                          o_ready,
    output logic                          o_hold,
    input  logic [lprf_pkg::COL_W-1:0]    i_rd_addr,
    input  logic [lprf_pkg::LEN_W-1:0]    i_rd_data,
    output logic                          o_wr_en,
    output logic [lprf_pkg::COL_W-1:0]    o_wr_addr,
    output logic [lprf_pkg::LEN_W-1:0]    o_wr_data,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // run_length, start_row, start_col, end_row, end_col, zero fill
    output logic [lprf_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // found
    output logic                          o_m_tuser
);
    import lprf_pkg::*;

    logic             r_valid;
    t_pix             r_pix;
    logic             r_fwd_hit;
    logic [LEN_W-1:0] r_fwd_data;
    logic [LEN_W-1:0] r_run_len;
    logic [COL_W-1:0] r_run_start;
    logic [LEN_W-1:0] r_best_len;
    logic [ROW_W-1:0] r_best_row;
    logic [COL_W-1:0] r_best_col;
    logic             r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic             r_out_found;

    logic             done;
    logic [LEN_W-1:0] col_prev;
    logic [LEN_W-1:0] run_base;
    logic [LEN_W-1:0] n_run_len;
    logic [COL_W-1:0] n_run_start;
    logic [LEN_W-1:0] vert_len;
    logic             offer_en;
    logic [LEN_W-1:0] offer_len;
    logic [ROW_W-1:0] offer_row;
    logic [COL_W-1:0] offer_col;
    logic             better;
    logic [LEN_W-1:0] n_best_len;
    logic [ROW_W-1:0] n_best_row;
    logic [COL_W-1:0] n_best_col;
    logic [POS_W-1:0] end_row;
    logic [POS_W-1:0] end_col;
    logic [LEN_W-1:0] len_m1;

    assign done    = r_valid && (!r_pix.last || !r_out_valid || i_m_tready);
    assign o_ready = !r_valid || done;
    assign o_hold  = r_valid && !done;

    assign col_prev = r_fwd_hit ? r_fwd_data : i_rd_data;

    always_comb begin
        run_base    = (r_pix.col == '0) ? '0 : r_run_len;
        n_run_len   = r_run_len;
        n_run_start = r_run_start;
        vert_len    = '0;
        offer_en    = 1'b0;
        offer_len   = '0;
        offer_row   = r_pix.row;
        offer_col   = r_pix.col;
        if (!r_pix.dir) begin
            if (r_pix.set) begin
                if (run_base == '0) begin
                    n_run_start = r_pix.col;
                end
                n_run_len = run_base + LEN_W'(1);
                offer_en  = 1'b1;
                offer_len = n_run_len;
                offer_col = n_run_start;
            end else begin
                n_run_len = '0;
            end
        end else begin
            if (r_pix.set) begin
                vert_len  = (r_pix.row == '0) ? LEN_W'(1) : col_prev + LEN_W'(1);
                offer_en  = 1'b1;
                offer_len = vert_len;
                offer_row = ROW_W'(LEN_W'(r_pix.row) + LEN_W'(1) - vert_len);
            end
        end
    end

    assign better = offer_en && (offer_len > r_best_len ||
        (offer_len == r_best_len && (offer_row < r_best_row ||
        (offer_row == r_best_row && offer_col < r_best_col))));

    assign n_best_len = better ? offer_len : r_best_len;
    assign n_best_row = better ? offer_row : r_best_row;
    assign n_best_col = better ? offer_col : r_best_col;

    assign len_m1  = n_best_len - LEN_W'(1);
    assign end_row = r_pix.dir ? POS_W'(LEN_W'(n_best_row) + len_m1) : POS_W'(n_best_row);
    assign end_col = r_pix.dir ? POS_W'(n_best_col) : POS_W'(LEN_W'(n_best_col) + len_m1);

    assign o_wr_en   = done && r_pix.dir;
    assign o_wr_addr = r_pix.col;
    assign o_wr_data = vert_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_run_len   <= '0;
            r_run_start <= '0;
            r_best_len  <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else begin
            r_fwd_hit <= o_wr_en && (o_wr_addr == i_rd_addr);
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (done) begin
                if (r_pix.last) begin
                    r_out_valid <= 1'b1;
                    r_run_len   <= '0;
                    r_run_start <= '0;
                    r_best_len  <= '0;
                    r_best_row  <= '0;
                    r_best_col  <= '0;
                end else begin
                    r_run_len   <= n_run_len;
                    r_run_start <= n_run_start;
                    r_best_len  <= n_best_len;
                    r_best_row  <= n_best_row;
                    r_best_col  <= n_best_col;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= o_wr_data;
        if (o_ready && i_valid) begin
            r_pix <= i_pix;
        end
        if (done && r_pix.last) begin
            if (n_best_len == '0) begin
                r_out_found <= 1'b0;
                r_out_data  <= '0;
            end else begin
                r_out_found <= 1'b1;
                r_out_data  <= {5'd0, end_col, end_row, POS_W'(n_best_col),
                                POS_W'(n_best_row), n_best_len};
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_found;

endmodule

>>> tb/longest_pixel_run_finder_tb.sv
// Testbench for longest_pixel_run_finder: streams binary images and checks each run report
// against an in-bench scan model of the longest horizontal or vertical pixel run.
// Depends on lprf_pkg and the longest_pixel_run_finder RTL.
`timescale 1ns / 1ps

module longest_pixel_run_finder_tb;
    import lprf_pkg::*;

    localparam logic DIR_HORIZONTAL = 1'b0;
    localparam logic DIR_VERTICAL   = 1'b1;

    typedef struct packed {
        logic        found;
        logic [10:0] run_length;
        logic [9:0]  start_row;
        logic [9:0]  start_col;
        logic [9:0]  end_row;
        logic [9:0]  end_col;
    } t_run_report;

    // m_axis_tdata layout, lowest field last
    typedef struct packed {
        logic [4:0]  fill;
        logic [9:0]  end_col;
        logic [9:0]  end_row;
        logic [9:0]  start_col;
        logic [9:0]  start_row;
        logic [10:0] run_length;
    } t_report_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CNT_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    longest_pixel_run_finder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // scan model state
    logic [10:0] cfg_rows = 11'd1;
    logic [10:0] cfg_cols = 11'd1;
    logic        cfg_dir  = DIR_HORIZONTAL;
    int          scan_row, scan_col;
    int          hrun_len, hrun_start;
    int          vrun_len [MAX_COLS];
    int          best_len, best_row, best_col;

    t_run_report expected_reports[$];
    int          mismatch_count;
    int          pixels_sent;
    int          images_sent;

    // sender and receiver pacing
    int          burst_left;
    bit          gaps_on = 1'b1;
    int          rx_hold_req;
    int          rx_hold_left;
    int          rx_mode;
    int          rx_mode_left;

    function automatic int eff_count(input logic [10:0] v, input int maxv);
        if (v == 0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic void clear_image();
        scan_row = 0;
        scan_col = 0;
        hrun_len = 0;
        hrun_start = 0;
        best_len = 0;
        best_row = 0;
        best_col = 0;
    endfunction

    function automatic void offer_run(input int len, input int srow, input int scol);
        if (len > best_len ||
            (len == best_len && (srow < best_row || (srow == best_row && scol < best_col)))) begin
            best_len = len;
            best_row = srow;
            best_col = scol;
        end
    endfunction

    function automatic void scan_pixel(input logic px);
        int          rows, cols, r, c, len;
        bit          row_end, last_px;
        t_run_report rep;
        rows = eff_count(cfg_rows, MAX_ROWS);
        cols = eff_count(cfg_cols, MAX_COLS);
        r = scan_row;
        c = scan_col;
        row_end = c >= cols - 1;
        last_px = row_end && r >= rows - 1;
        if (cfg_dir == DIR_HORIZONTAL) begin
            if (c == 0) hrun_len = 0;
            if (px) begin
                if (hrun_len == 0) hrun_start = c;
                hrun_len++;
                offer_run(hrun_len, r, hrun_start);
            end else begin
                hrun_len = 0;
            end
        end else begin
            len = 0;
            if (px) begin
                len = (r == 0) ? 1 : vrun_len[c] + 1;
                offer_run(len, r + 1 - len, c);
            end
            vrun_len[c] = len;
        end
        if (!last_px) begin
            if (row_end) begin
                scan_col = 0;
                scan_row = r + 1;
            end else begin
                scan_col = c + 1;
            end
        end else begin
            rep = '0;
            if (best_len != 0) begin
                rep.found      = 1'b1;
                rep.run_length = 11'(best_len);
                rep.start_row  = 10'(best_row);
                rep.start_col  = 10'(best_col);
                rep.end_row    = (cfg_dir == DIR_VERTICAL) ? 10'(best_row + best_len - 1)
                                                           : 10'(best_row);
                rep.end_col    = (cfg_dir == DIR_VERTICAL) ? 10'(best_col)
                                                           : 10'(best_col + best_len - 1);
            end
            expected_reports.push_back(rep);
            clear_image();
        end
    endfunction

    // receiver: own stall pattern, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(2);
                rx_mode_left = $urandom_range(80, 10);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= 1'($urandom_range(1));
                end
                default: begin
                    m_axis_tready <= ($urandom_range(3) == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : check_reports
        t_report_word word;
        t_run_report  got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            word = m_axis_tdata;
            got.found      = m_axis_tuser;
            got.run_length = word.run_length;
            got.start_row  = word.start_row;
            got.start_col  = word.start_col;
            got.end_row    = word.end_row;
            got.end_col    = word.end_col;
            if (expected_reports.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected report: found=%0d len=%0d start=(%0d,%0d) end=(%0d,%0d)",
                             got.found, got.run_length, got.start_row, got.start_col,
                             got.end_row, got.end_col);
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                if (got.found !== want.found || got.run_length !== want.run_length ||
                    got.start_row !== want.start_row || got.start_col !== want.start_col ||
                    got.end_row !== want.end_row || got.end_col !== want.end_col) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch at %0t:", $realtime);
                        $display("  expected found=%0d len=%0d start=(%0d,%0d) end=(%0d,%0d)",
                                 want.found, want.run_length, want.start_row, want.start_col,
                                 want.end_row, want.end_col);
                        $display("  actual   found=%0d len=%0d start=(%0d,%0d) end=(%0d,%0d)",
                                 got.found, got.run_length, got.start_row, got.start_col,
                                 got.end_row, got.end_col);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // one pixel word; valid stays high afterwards, callers lower it or send again
    task automatic send_pixel(input logic px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            if (gaps_on) begin
                gap = $urandom_range(6, 1);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, px};
        do @(posedge i_clk); while (!s_axis_tready);
        scan_pixel(px);
        pixels_sent++;
    endtask

    // stop sending, let every report arrive and the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [10:0] rows, input logic [10:0] cols,
                                input logic dir);
        logic [CFG_IDX_W-1:0] idx  [3];
        logic [10:0]          vals [3];
        idx[0] = REG_ROW_COUNT;
        idx[1] = REG_COL_COUNT;
        idx[2] = REG_DIRECTION;
        vals[0] = rows;
        vals[1] = cols;
        vals[2] = {10'b0, dir};
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[i])
                REG_ROW_COUNT: cfg_rows = vals[i];
                REG_COL_COUNT: cfg_cols = vals[i];
                REG_DIRECTION: cfg_dir  = vals[i][0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // sends n pixels, written left to right in bits
    task automatic send_pattern(input logic [31:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--) send_pixel(bits[i]);
        images_sent++;
    endtask

    task automatic send_tail_run(input int n, input int first_set);
        for (int i = 0; i < n; i++) send_pixel(i >= first_set);
        images_sent++;
    endtask

    task automatic send_random_image(input int density);
        int n;
        n = eff_count(cfg_rows, MAX_ROWS) * eff_count(cfg_cols, MAX_COLS);
        for (int i = 0; i < n; i++) send_pixel($urandom_range(99) < density);
        images_sent++;
    endtask

    function automatic logic [10:0] random_count();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 11'd0;
        if (pick == 1) return 11'($urandom_range(16, 9));
        return 11'($urandom_range(8, 1));
    endfunction

    function automatic int random_density();
        int levels [5] = '{0, 15, 50, 85, 100};
        return levels[$urandom_range(4)];
    endfunction

    task automatic test_horizontal_directed();
        // reset sizing is 1 x 1, horizontal
        send_pattern(32'b0, 1);
        send_pattern(32'b1, 1);
        wait_idle();
        // equal runs in two rows, upper row wins
        write_config(11'd2, 11'd3, DIR_HORIZONTAL);
        send_pattern(32'b011_110, 6);
        // runs must not join across the row boundary
        wait_idle();
        write_config(11'd2, 11'd2, DIR_HORIZONTAL);
        send_pattern(32'b01_10, 4);
    endtask

    task automatic test_vertical_directed();
        wait_idle();
        write_config(11'd3, 11'd2, DIR_VERTICAL);
        send_pattern(32'b11_11_01, 6);
        wait_idle();
        write_config(11'd2, 11'd2, DIR_VERTICAL);
        send_pattern(32'b11_11, 4);
        send_pattern(32'b00_00, 4);
        // zero counts act as one
        wait_idle();
        write_config(11'd0, 11'd0, DIR_VERTICAL);
        send_pattern(32'b1, 1);
    endtask

    task automatic test_size_extremes();
        // a long single row and a long single column, run reaching the far edge
        wait_idle();
        write_config(11'd1, 11'd64, DIR_HORIZONTAL);
        send_tail_run(64, 0);
        wait_idle();
        write_config(11'd64, 11'd1, DIR_VERTICAL);
        send_tail_run(64, 5);
    endtask

    task automatic test_back_pressure();
        wait_idle();
        write_config(11'd1, 11'd1, DIR_HORIZONTAL);
        gaps_on = 1'b0;
        rx_hold_req = 300;
        for (int i = 0; i < 40; i++) begin
            send_pixel(1'($urandom_range(1)));
            images_sent++;
        end
        gaps_on = 1'b1;
        wait_idle();
        write_config(11'd2, 11'd3, DIR_VERTICAL);
        rx_hold_req = 150;
        for (int i = 0; i < 6; i++) send_random_image(50);
    endtask

    task automatic test_random_images();
        int start_pixels, start_images;
        start_pixels = pixels_sent;
        start_images = images_sent;
        while (pixels_sent - start_pixels < 360 || images_sent - start_images < 12) begin
            if ($urandom_range(1)) begin
                wait_idle();
                write_config(random_count(), random_count(), 1'($urandom_range(1)));
            end else if ($urandom_range(7) == 0) begin
                wait_idle();
            end
            gaps_on = $urandom_range(9) < 7;
            send_random_image(random_density());
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_image();
        @(posedge i_clk);
        test_horizontal_directed();
        test_vertical_directed();
        test_size_extremes();
        test_back_pressure();
        test_random_images();
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout: %0d reports still pending", expected_reports.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
rtl/lprf_pkg.sv
rtl/lprf_ram.sv
rtl/lprf_cfg.sv
rtl/lprf_track.sv
rtl/longest_pixel_run_finder.sv
tb/longest_pixel_run_finder_tb.sv
